// File: rtl/pba_pkg.sv
// Package for the power-of-two bucket allocator.
// Holds field widths, status codes and the sequencer state type.
// No dependencies.
`default_nettype none

package pba_pkg;

  localparam int WIDE_W       = 33;  // size and pool arithmetic
  localparam int SIZE_W       = 32;
  localparam int ADDR_W       = 20;
  localparam int BKT_W        = 5;
  localparam int STAT_W       = 3;
  localparam int CFG_W        = 5;
  localparam int HEADER_BYTES = 4;
  localparam int MIN_BLOCK    = 8;

  localparam logic [CFG_W-1:0] PAGE_LG_RESET = 5'd12;
  localparam logic [CFG_W-1:0] PAGE_LG_MIN   = 5'd8;
  localparam logic [CFG_W-1:0] PAGE_LG_MAX   = 5'd16;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_MEM    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_FREE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NULL_FREE = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIZE,
    S_PROBE,
    S_ROOM,
    S_ROOM_CHK,
    S_CARVE,
    S_POP_RD,
    S_POP_WR,
    S_FREE_RD,
    S_FREE_CHK,
    S_FREE_PUSH,
    S_RESP
  } pba_state_t;

endpackage

`default_nettype wire

// File: rtl/pba_alu.sv
// Shared add and compare unit of the allocator sequencer.
// Depends on pba_pkg for the datapath width.
`default_nettype none

module pba_alu (
  input  wire logic [pba_pkg::WIDE_W-1:0] a,
  input  wire logic [pba_pkg::WIDE_W-1:0] b,
  input  wire logic [pba_pkg::WIDE_W-1:0] c,
  output logic      [pba_pkg::WIDE_W-1:0] sum,
  output logic                            lt
);
  import pba_pkg::*;

  assign sum = a + b;
  assign lt  = (a < c);

endmodule

`default_nettype wire

// File: rtl/pba_header_ram.sv
// Block header store: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module pba_header_ram #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17,
  parameter int DW    = 19
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/pow2_bucket_allocator_unit.sv
// Top level of the power-of-two bucket allocator: sequencer, bucket heads,
// bump pointer and result register. Depends on pba_pkg, pba_alu and
// pba_header_ram.
//
//  channel | signals                                   | dir | transfer
//  --------+-------------------------------------------+-----+------------------------
//  in      | action, request_size, block_address       | in  | in_valid & in_ready
//  out     | address_out, bucket, usable_bytes, status | out | out_valid & out_ready
//  cfg     | cfg_data (page_size_log2)                 | in  | cfg_valid & cfg_ready
//
// Steps: a valid free passes the range check and header read, the header check and
// the push before the result register. An allocate rounds the size up bucket by
// bucket in the shared add/compare unit, probes the bucket head, then pops a block;
// an empty bucket adds a pool check and a carve step per carved block (page / block
// size, or 1) plus a closing step, bounded by the single write port of the header store.
// Reset clears the bucket valid bits and bump pointer; the header store is not
// cleared. in_ready is high only in idle; a result waiting in the output
// register does not block the next transfer, only the next result.
`default_nettype none

module pow2_bucket_allocator_unit #(
  parameter int POOL_BYTES  = 1048576,
  parameter int NUM_BUCKETS = 29
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         action,
  input  wire logic [pba_pkg::SIZE_W-1:0]   request_size,
  input  wire logic [pba_pkg::ADDR_W-1:0]   block_address,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [pba_pkg::ADDR_W-1:0]   address_out,
  output logic      [pba_pkg::BKT_W-1:0]    bucket,
  output logic      [pba_pkg::ADDR_W-1:0]   usable_bytes,
  output logic      [pba_pkg::STAT_W-1:0]   status,
  // configuration channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pba_pkg::CFG_W-1:0]    cfg_data
);
  import pba_pkg::*;

  localparam int GRANULES = POOL_BYTES / 8;
  localparam int GW       = $clog2(GRANULES);
  localparam int HDR_W    = GW + 2;          // {alloc tag, link valid, link/bucket}
  localparam int PW       = $clog2(POOL_BYTES) + 1;
  localparam int HIW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(NUM_BUCKETS - 1);

  pba_state_t state, state_next;

  // captured request
  logic [SIZE_W-1:0]   req;
  logic [ADDR_W-1:0]   baddr;

  // working registers
  logic [WIDE_W-1:0]   n;        // block size under test
  logic [WIDE_W-1:0]   need;     // request plus header
  logic [BKT_W-1:0]    bkt;
  logic [WIDE_W-1:0]   amount;   // bytes to carve on refill
  logic [WIDE_W-1:0]   tmp;      // bump + amount, end of carve
  logic [PW-1:0]       bump;
  logic [PW-1:0]       ptr;      // carve pointer
  logic [GW-1:0]       free_g;
  logic [CFG_W-1:0]    page_lg;

  // bucket heads: valid bits reset, granules are payload
  logic [NUM_BUCKETS-1:0] head_valid;
  logic [GW-1:0]          head_g [NUM_BUCKETS];

  // staged result
  logic [ADDR_W-1:0]   res_addr;
  logic [BKT_W-1:0]    res_bkt;
  logic [ADDR_W-1:0]   res_usable;
  logic [STAT_W-1:0]   res_status;

  // shared unit
  logic [WIDE_W-1:0]   alu_a, alu_b, alu_c, alu_sum;
  logic                alu_lt;

  // header store port
  logic                mem_we;
  logic [GW-1:0]       mem_waddr, mem_raddr;
  logic [HDR_W-1:0]    mem_wdata, rd_data;

  // helpers
  logic [HIW-1:0]      bidx;
  logic [ADDR_W-1:0]   base;
  logic [WIDE_W-1:0]   base_w, ptr_w, alloc_addr_w, alloc_usable_w, free_usable_w;
  logic [GW-1:0]       base_g, ptr_g;
  logic [CFG_W-1:0]    lg;
  logic [WIDE_W-1:0]   page;
  logic                req_bad, slot_free;
  logic                free_early_bad, hdr_bad;

  assign bidx           = bkt[HIW-1:0];
  assign base           = baddr - ADDR_W'(HEADER_BYTES);
  assign base_w         = WIDE_W'(base);
  assign base_g         = base_w[GW+2:3];
  assign ptr_w          = WIDE_W'(ptr);
  assign ptr_g          = ptr_w[GW+2:3];
  assign alloc_addr_w   = (WIDE_W'(head_g[bidx]) << 3) + WIDE_W'(HEADER_BYTES);
  assign alloc_usable_w = n - WIDE_W'(HEADER_BYTES);
  assign free_usable_w  = (WIDE_W'(MIN_BLOCK) << bkt) - WIDE_W'(HEADER_BYTES);
  assign req_bad        = (req == '0) || req[SIZE_W-1];
  assign slot_free      = !out_valid || out_ready;

  // page size saturates to the supported range
  assign lg   = (page_lg < PAGE_LG_MIN) ? PAGE_LG_MIN :
                (page_lg > PAGE_LG_MAX) ? PAGE_LG_MAX : page_lg;
  assign page = WIDE_W'(1) << lg;

  // free range: null, below header, misaligned, or past the bump pointer
  assign free_early_bad = (baddr < ADDR_W'(HEADER_BYTES)) || (base[2:0] != 3'd0) || !alu_lt;
  assign hdr_bad        = !rd_data[HDR_W-1] ||
                          (rd_data[BKT_W-1:0] >= BKT_W'(NUM_BUCKETS));

  // operand select for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_c = '0;
    case (state)
      S_SIZE: begin
        alu_a = n;
        alu_b = n;
        alu_c = need;
      end
      S_ROOM: begin
        alu_a = WIDE_W'(bump);
        alu_b = amount;
      end
      S_ROOM_CHK: begin
        alu_a = WIDE_W'(POOL_BYTES);
        alu_c = tmp;
      end
      S_CARVE: begin
        alu_a = ptr_w;
        alu_b = n;
        alu_c = tmp;
      end
      S_FREE_RD: begin
        alu_a = base_w;
        alu_c = WIDE_W'(bump);
      end
      default: begin
      end
    endcase
  end

  pba_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .sum (alu_sum),
    .lt  (alu_lt)
  );

  pba_header_ram #(
    .DEPTH (GRANULES),
    .AW    (GW),
    .DW    (HDR_W)
  ) u_hdr (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = action ? S_FREE_RD : S_SIZE;
        end
      end
      S_SIZE: begin
        if (req_bad || (alu_lt && bkt == LAST_BKT)) begin
          state_next = S_RESP;
        end else if (!alu_lt) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE:     state_next = head_valid[bidx] ? S_POP_RD : S_ROOM;
      S_ROOM:      state_next = S_ROOM_CHK;
      S_ROOM_CHK:  state_next = alu_lt ? S_RESP : S_CARVE;
      S_CARVE:     state_next = alu_lt ? S_CARVE : S_POP_RD;
      S_POP_RD:    state_next = S_POP_WR;
      S_POP_WR:    state_next = S_RESP;
      S_FREE_RD:   state_next = (baddr == '0 || free_early_bad) ? S_RESP : S_FREE_CHK;
      S_FREE_CHK:  state_next = hdr_bad ? S_RESP : S_FREE_PUSH;
      S_FREE_PUSH: state_next = S_RESP;
      S_RESP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // handshakes and header store controls
  always_comb begin
    in_ready  = (state == S_IDLE);
    cfg_ready = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = ptr_g;
    mem_wdata = {1'b0, head_valid[bidx], head_g[bidx]};
    mem_raddr = (state == S_POP_RD) ? head_g[bidx] : base_g;
    case (state)
      S_CARVE: begin
        mem_we = alu_lt;
      end
      S_POP_WR: begin
        // tag the popped block as allocated to this bucket
        mem_we    = 1'b1;
        mem_waddr = head_g[bidx];
        mem_wdata = {1'b1, 1'b0, GW'(bkt)};
      end
      S_FREE_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = free_g;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_valid <= '0;
      bump       <= '0;
      page_lg    <= PAGE_LG_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        page_lg <= cfg_data;
      end
      case (state)
        S_ROOM_CHK: begin
          if (!alu_lt) begin
            bump <= tmp[PW-1:0];
          end
        end
        S_CARVE: begin
          if (alu_lt) begin
            head_valid[bidx] <= 1'b1;
          end
        end
        S_POP_WR: begin
          head_valid[bidx] <= rd_data[HDR_W-2];
        end
        S_FREE_PUSH: begin
          head_valid[bidx] <= 1'b1;
        end
        default: begin
        end
      endcase
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_RESP && slot_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req   <= request_size;
          baddr <= block_address;
          n     <= WIDE_W'(MIN_BLOCK);
          need  <= WIDE_W'(request_size) + WIDE_W'(HEADER_BYTES);
          bkt   <= '0;
        end
      end
      S_SIZE: begin
        if (req_bad || (alu_lt && bkt == LAST_BKT)) begin
          res_addr   <= '0;
          res_bkt    <= '0;
          res_usable <= '0;
          res_status <= ST_BAD_SIZE;
        end else if (alu_lt) begin
          n   <= alu_sum;
          bkt <= bkt + BKT_W'(1);
        end
      end
      S_PROBE: begin
        amount <= (n <= page) ? page : n;
      end
      S_ROOM: begin
        tmp <= alu_sum;
      end
      S_ROOM_CHK: begin
        ptr <= bump;
        if (alu_lt) begin
          res_addr   <= '0;
          res_bkt    <= bkt;
          res_usable <= '0;
          res_status <= ST_NO_MEM;
        end
      end
      S_CARVE: begin
        // push carved blocks in ascending order; the last one ends on top
        if (alu_lt) begin
          head_g[bidx] <= ptr_g;
          ptr          <= alu_sum[PW-1:0];
        end
      end
      S_POP_WR: begin
        head_g[bidx] <= rd_data[GW-1:0];
        res_addr     <= alloc_addr_w[ADDR_W-1:0];
        res_bkt      <= bkt;
        res_usable   <= alloc_usable_w[ADDR_W-1:0];
        res_status   <= ST_OK;
      end
      S_FREE_RD: begin
        free_g     <= base_g;
        res_addr   <= '0;
        res_bkt    <= '0;
        res_usable <= '0;
        res_status <= (baddr == '0) ? ST_NULL_FREE : ST_BAD_FREE;
      end
      S_FREE_CHK: begin
        bkt <= rd_data[BKT_W-1:0];
      end
      S_FREE_PUSH: begin
        head_g[bidx] <= free_g;
        res_bkt      <= bkt;
        res_usable   <= free_usable_w[ADDR_W-1:0];
        res_status   <= ST_OK;
      end
      S_RESP: begin
        if (slot_free) begin
          address_out  <= res_addr;
          bucket       <= res_bkt;
          usable_bytes <= res_usable;
          status       <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: verif/pow2_bucket_allocator_unit_test.sv
// Self-checking testbench for pow2_bucket_allocator_unit: allocate and free traffic,
// scoreboarded against an in-bench allocator model. Imports pba_pkg; needs only the RTL.
`timescale 1ns / 1ps

module pow2_bucket_allocator_unit_test;
  import pba_pkg::*;

  localparam int POOL_SIZE     = 1048576;
  localparam int BUCKET_COUNT  = 29;
  localparam int GRANULE_COUNT = POOL_SIZE / 8;
  localparam int HEAD_LIVE_BIT = 17;      // bucket head / free link valid
  localparam int HDR_USED_BIT  = 23;      // header tag: block handed out
  localparam int PHASE_ITEMS   = 106;
  localparam int DRAIN_CYCLES  = 40;      // longest allocate without a refill, padded
  localparam int HOLD_AT       = 200;     // results seen before the long receiver hold
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  typedef struct packed {
    logic              act;
    logic [SIZE_W-1:0] sz;
    logic [ADDR_W-1:0] ua;
  } alloc_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BKT_W-1:0]  bkt;
    logic [ADDR_W-1:0] usable;
    logic [STAT_W-1:0] st;
  } alloc_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_EVERY3, RX_RARE} rx_mode_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              action = 1'b0;
  logic [SIZE_W-1:0] request_size = '0;
  logic [ADDR_W-1:0] block_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] address_out;
  logic [BKT_W-1:0]  bucket;
  logic [ADDR_W-1:0] usable_bytes;
  logic [STAT_W-1:0] status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  pow2_bucket_allocator_unit #(
    .POOL_BYTES  (POOL_SIZE),
    .NUM_BUCKETS (BUCKET_COUNT)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .request_size  (request_size),
    .block_address (block_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .address_out   (address_out),
    .bucket        (bucket),
    .usable_bytes  (usable_bytes),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Allocator model state
  // ---------------------------------------------------------------------------
  bit [17:0]        head_tbl [BUCKET_COUNT];     // top of each bucket's free stack
  bit [23:0]        hdr_mem  [GRANULE_COUNT];    // per-granule header / free link
  bit               hdr_set  [GRANULE_COUNT];    // header ever written (block base)
  int unsigned      pool_top = 0;                // bump pointer
  logic [CFG_W-1:0] page_lg  = PAGE_LG_RESET;

  logic [ADDR_W-1:0] live_q[$];                  // addresses currently handed out
  logic [ADDR_W-1:0] released_q[$];              // recently freed, for double frees

  alloc_req_t    pend_q[$];                      // items waiting for the driver
  alloc_result_t due_results[$];                 // predicted, not yet seen on output

  int n_queued   = 0;
  int n_accepted = 0;
  int n_fail     = 0;
  int n_grant    = 0;
  int n_release  = 0;
  int n_phases   = 1;
  int hits [5];

  logic [CFG_W-1:0] page_plan [5] = '{5'd0, 5'd8, 5'd12, 5'd31, 5'd16};

  // Push a block onto a bucket stack; its header becomes the old head link.
  function automatic void stack_push(input int idx, input int unsigned base);
    int unsigned g;
    g = base >> 3;
    hdr_mem[g] = {6'b0, head_tbl[idx]};
    hdr_set[g] = 1'b1;
    head_tbl[idx] = {1'b1, 17'(g)};
  endfunction

  function automatic void forget_live(input logic [ADDR_W-1:0] ua);
    int k;
    for (k = 0; k < live_q.size(); k++) begin
      if (live_q[k] == ua) begin
        live_q.delete(k);
        break;
      end
    end
  endfunction

  function automatic alloc_result_t respond_alloc(input logic [SIZE_W-1:0] sz);
    alloc_result_t    r;
    longint unsigned  want, blk, page, span, nblk, k;
    int unsigned      g;
    int               idx;
    logic [CFG_W-1:0] lg;
    r = '0;
    if (sz == '0 || sz[SIZE_W-1]) begin
      r.st = ST_BAD_SIZE;
      return r;
    end
    want = 64'(sz) + HEADER_BYTES;
    blk = 64'(MIN_BLOCK);
    idx = 0;
    while (blk < want) begin
      blk = blk << 1;
      idx++;
    end
    if (idx >= BUCKET_COUNT) begin
      r.st = ST_BAD_SIZE;
      return r;
    end
    // empty bucket: carve a page (or one oversize block) from the bump pointer
    if (!head_tbl[idx][HEAD_LIVE_BIT]) begin
      lg = page_lg;
      if (lg < PAGE_LG_MIN) lg = PAGE_LG_MIN;
      if (lg > PAGE_LG_MAX) lg = PAGE_LG_MAX;
      page = 64'd1 << lg;
      if (blk <= page) begin
        span = page;
        nblk = page / blk;
      end else begin
        span = blk;
        nblk = 1;
      end
      if (span > 64'(POOL_SIZE) - pool_top) begin
        r.bkt = BKT_W'(idx);
        r.st  = ST_NO_MEM;
        return r;
      end
      for (k = 0; k < nblk; k++) stack_push(idx, 32'(pool_top + k * blk));
      pool_top = 32'(pool_top + span);
    end
    g = 32'(head_tbl[idx][16:0]);
    head_tbl[idx] = hdr_mem[g][17:0];
    hdr_mem[g] = 24'(1 << HDR_USED_BIT) | 24'(idx);
    r.addr   = ADDR_W'((g << 3) + HEADER_BYTES);
    r.bkt    = BKT_W'(idx);
    r.usable = ADDR_W'(blk - HEADER_BYTES);
    r.st     = ST_OK;
    live_q.push_back(r.addr);
    return r;
  endfunction

  function automatic alloc_result_t respond_free(input logic [ADDR_W-1:0] ua);
    alloc_result_t r;
    int unsigned   base;
    bit [23:0]     h;
    int            idx;
    r = '0;
    if (ua == '0) begin
      r.st = ST_NULL_FREE;
      return r;
    end
    if (ua < HEADER_BYTES) begin
      r.st = ST_BAD_FREE;
      return r;
    end
    base = 32'(ua) - HEADER_BYTES;
    if (base[2:0] != 3'd0 || base >= pool_top) begin
      r.st = ST_BAD_FREE;
      return r;
    end
    h = hdr_mem[base >> 3];
    idx = int'(h[4:0]);
    // not handed out (covers double frees) or a corrupt bucket tag
    if (!h[HDR_USED_BIT] || idx >= BUCKET_COUNT) begin
      r.st = ST_BAD_FREE;
      return r;
    end
    stack_push(idx, base);
    r.bkt    = BKT_W'(idx);
    r.usable = ADDR_W'((1 << (idx + 3)) - HEADER_BYTES);
    r.st     = ST_OK;
    forget_live(ua);
    released_q.push_back(ua);
    if (released_q.size() > 16) void'(released_q.pop_front());
    return r;
  endfunction

  function automatic alloc_result_t respond(input alloc_req_t it);
    if (it.act == ACT_FREE) return respond_free(it.ua);
    return respond_alloc(it.sz);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: request channel, bursts with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    alloc_req_t nxt;
    int         burst_left;
    int         gap_left;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 4;
      gap_left   = 0;
    end else if (!in_valid || in_ready) begin
      // slot is free after this edge (nothing held, or the held item transfers now)
      if (pend_q.size() != 0 && gap_left == 0) begin
        nxt = pend_q.pop_front();
        in_valid      <= 1'b1;
        action        <= nxt.act;
        request_size  <= nxt.sz;
        block_address <= nxt.ua;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
        if (pend_q.size() != 0 && gap_left != 0) gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_ready pattern, plus one long hold to back up the pipe
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ready
    rx_mode_t rx_mode;
    int       seg_left;
    int       rx_count;
    int       hold_left;
    bit       hold_done;
    if (rst) begin
      out_ready <= 1'b0;
      rx_mode   = RX_OPEN;
      seg_left  = 0;
      rx_count  = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) rx_count++;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && rx_count >= HOLD_AT) begin
        // sender keeps offering; block takes one more and then stalls its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          rx_mode  = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 120);
        end else begin
          seg_left--;
        end
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_EVERY3: out_ready <= (seg_left % 3 == 0);
          default:   out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result transfers, then predict for request transfers.
  // One block, so the order of pop and push within an edge is fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    alloc_result_t want;
    alloc_req_t    got_req;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          n_fail++;
          $error("result transfer with nothing expected");
        end else begin
          want = due_results.pop_front();
          if (address_out !== want.addr) begin
            n_fail++;
            $error("address_out mismatch: expected %0h, got %0h", want.addr, address_out);
          end
          if (bucket !== want.bkt) begin
            n_fail++;
            $error("bucket mismatch: expected %0d, got %0d", want.bkt, bucket);
          end
          if (usable_bytes !== want.usable) begin
            n_fail++;
            $error("usable_bytes mismatch: expected %0d, got %0d",
                   want.usable, usable_bytes);
          end
          if (status !== want.st) begin
            n_fail++;
            $error("status mismatch: expected %0d, got %0d", want.st, status);
          end
        end
      end
      if (in_valid && in_ready) begin
        got_req.act = action;
        got_req.sz  = request_size;
        got_req.ua  = block_address;
        want = respond(got_req);
        due_results.push_back(want);
        hits[want.st]++;
        if (want.st == ST_OK) begin
          if (action == ACT_FREE) n_release++;
          else n_grant++;
        end
        n_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Queue one item at a falling edge and wait for its transfer, so the model
  // is current when the next item (and its free address) is chosen.
  task automatic send_item(input logic act, input logic [SIZE_W-1:0] sz,
                           input logic [ADDR_W-1:0] ua);
    alloc_req_t it;
    it.act = act;
    it.sz  = sz;
    it.ua  = ua;
    @(negedge clk);
    pend_q.push_back(it);
    n_queued++;
    do @(negedge clk); while (n_accepted != n_queued);
  endtask

  task automatic quiesce();
    while (due_results.size() != 0 || n_accepted != n_queued) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_page_lg(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    page_lg = v;
  endtask

  // Mostly small blocks, a tail of page-sized and multi-page ones.
  function automatic logic [SIZE_W-1:0] draw_size();
    int r;
    r = $urandom_range(0, 999);
    if (r < 700) return $urandom_range(1, 60);
    if (r < 900) return $urandom_range(61, 1020);
    if (r < 985) return $urandom_range(1021, 8188);
    return $urandom_range(8189, 131068);
  endfunction

  function automatic logic [SIZE_W-1:0] odd_size();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return '0;
      2:       return 32'h8000_0000 | $urandom;
      default: return $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
    endcase
  endfunction

  // A free must never land on a granule inside the pool that was never a
  // block base; knock such an address off alignment so it is rejected early.
  function automatic logic [ADDR_W-1:0] guard_free_addr(input logic [ADDR_W-1:0] ua);
    logic [ADDR_W-1:0] g;
    g = ua;
    if (g >= HEADER_BYTES && g[2:0] == 3'(HEADER_BYTES) &&
        (32'(g) - HEADER_BYTES) < pool_top && !hdr_set[(32'(g) - HEADER_BYTES) >> 3])
      g[0] = 1'b1;
    return g;
  endfunction

  task automatic random_item();
    int                pick;
    logic [ADDR_W-1:0] ua;
    pick = $urandom_range(0, 99);
    if (pick < 50 || (pick < 80 && live_q.size() == 0)) begin
      send_item(ACT_ALLOC, draw_size(), ADDR_W'($urandom_range(0, ADDR_MAX)));
    end else if (pick < 80) begin
      send_item(ACT_FREE, $urandom, live_q[$urandom_range(0, live_q.size() - 1)]);
    end else if (pick < 86 && released_q.size() != 0) begin
      // stale address: double free, or a legal free if it was handed out again
      send_item(ACT_FREE, $urandom, released_q[$urandom_range(0, released_q.size() - 1)]);
    end else if (pick < 94) begin
      if (live_q.size() != 0 && $urandom_range(0, 1) == 1)
        ua = live_q[$urandom_range(0, live_q.size() - 1)] + ADDR_W'(8 * $urandom_range(1, 4));
      else
        ua = ADDR_W'($urandom_range(0, ADDR_MAX));
      if ($urandom_range(0, 7) == 0) ua = '0;
      send_item(ACT_FREE, $urandom, guard_free_addr(ua));
    end else begin
      send_item(ACT_ALLOC, odd_size(), ADDR_W'($urandom_range(0, ADDR_MAX)));
    end
  endtask

  initial begin : run_test
    logic [ADDR_W-1:0] a_small, a_page, a_big;
    int                p;
    foreach (hits[i]) hits[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset page size (4 KiB)
    send_item(ACT_ALLOC, 32'd1, ADDR_MAX);        // first refill of the smallest bucket
    a_small = live_q[$];
    send_item(ACT_ALLOC, 32'd4, '0);              // exactly fills an 8-byte block
    send_item(ACT_ALLOC, 32'd5, '0);              // spills into the 16-byte bucket
    send_item(ACT_ALLOC, 32'd0, '0);              // zero size
    send_item(ACT_ALLOC, 32'h8000_0000, '0);      // top bit set
    send_item(ACT_ALLOC, 32'hFFFF_FFFF, ADDR_MAX);
    send_item(ACT_ALLOC, 32'h7FFF_FFFD, '0);      // rounds past the last bucket
    send_item(ACT_ALLOC, 32'h7FFF_FFFC, '0);      // last bucket, bigger than the pool
    send_item(ACT_ALLOC, 32'h3FFF_FFFC, '0);      // out of memory
    send_item(ACT_ALLOC, 32'd4092, '0);           // block equals one page
    a_page = live_q[$];
    send_item(ACT_ALLOC, 32'd4093, '0);           // block larger than a page
    a_big = live_q[$];
    send_item(ACT_ALLOC, 32'd1048572, '0);        // whole pool, bump already moved
    send_item(ACT_FREE, 32'hFFFF_FFFF, 20'd0);    // null free
    send_item(ACT_FREE, '0, 20'd1);               // below the header
    send_item(ACT_FREE, '0, 20'd3);
    send_item(ACT_FREE, '0, 20'd4);               // carved block base, never handed out
    send_item(ACT_FREE, '0, 20'd6);               // misaligned
    send_item(ACT_FREE, '0, ADDR_MAX);
    send_item(ACT_FREE, '0, 20'hFFFFC);           // past the bump pointer
    send_item(ACT_FREE, '0, a_small);
    send_item(ACT_FREE, '0, a_small);             // double free
    send_item(ACT_FREE, '0, a_page);
    send_item(ACT_ALLOC, 32'd2, '0);              // LIFO: same block comes back
    send_item(ACT_FREE, '0, a_big);

    // Random phases over page sizes, saturating values included
    page_plan[2] = CFG_W'($urandom_range(9, 15));
    for (p = 0; p < 5; p++) begin
      quiesce();
      write_page_lg(page_plan[p]);
      n_phases++;
      repeat (PHASE_ITEMS) random_item();
    end

    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests over %0d page settings: %0d grants, %0d frees accepted",
             n_accepted, n_phases, n_grant, n_release);
    $display("Rejected: %0d bad size, %0d out of memory, %0d bad free, %0d null free",
             hits[ST_BAD_SIZE], hits[ST_NO_MEM], hits[ST_BAD_FREE], hits[ST_NULL_FREE]);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycles, due_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
